// ===== rtl/core/scvs_pkg.sv =====
// package for the supply compensated voltage sampler
// holds field widths, arithmetic constants, the sequencer state type and divider structs
// no dependencies
`timescale 1ns / 1ps

package scvs_pkg;

  localparam int unsigned KIND_W   = 1;
  localparam int unsigned ADC_W    = 10;
  localparam int unsigned MV_W     = 16;
  localparam int unsigned WAIT_W   = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned RAW_W    = 13;
  localparam int unsigned SUPPLY_W = 21;
  localparam int unsigned SCALED_W = 18;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned DEN_W    = 10;
  localparam int unsigned ITER_W   = 6;

  localparam logic [WAIT_W-1:0] SHORT_WAIT_RST = 16'd16;
  localparam logic [WAIT_W-1:0] LONG_WAIT_RST  = 16'd625;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WAIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WAIT  = 8'd1;

  localparam logic [KIND_W-1:0] KIND_TICK = 1'b0;
  localparam logic [KIND_W-1:0] KIND_CONV = 1'b1;
  localparam logic              RES_REQUEST = 1'b0;
  localparam logic              RES_VOLTAGE = 1'b1;
  localparam logic              CH_BATTERY  = 1'b0;

  localparam logic [RAW_W-1:0]    NOMINAL_MV   = 13'd5000;
  localparam logic [SUPPLY_W-1:0] REF_NUMER    = 21'd1126400;
  localparam logic [DEN_W-1:0]    FULL_SCALE   = 10'd1023;
  localparam logic [DEN_W-1:0]    SUPPLY_DIV   = 10'd5;
  localparam logic [DEN_W-1:0]    MV_PER_V     = 10'd1000;

  // dividend bits per division, quotient fills the low bits
  localparam logic [ITER_W-1:0] ITERS_RAW = 6'd23;
  localparam logic [ITER_W-1:0] ITERS_SUP = 6'd21;
  localparam logic [ITER_W-1:0] ITERS_SCL = 6'd21;
  localparam logic [ITER_W-1:0] ITERS_VLT = 6'd31;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_MUL_RAW = 8'b0000_0010,
    ST_DIV_RAW = 8'b0000_0100,
    ST_DIV_SUP = 8'b0000_1000,
    ST_DIV_SCL = 8'b0001_0000,
    ST_MUL_VLT = 8'b0010_0000,
    ST_DIV_VLT = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } scvs_state_e;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
    logic [DATA_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } scvs_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } scvs_div_rsp_t;

endpackage

// ===== rtl/core/scvs_if.sv =====
// handshake interfaces for the input, result and configuration channels
// depends on scvs_pkg
`timescale 1ns / 1ps

interface scvs_in_if;
  logic                          valid;
  logic                          ready;
  logic [scvs_pkg::KIND_W-1:0]   kind;
  logic [scvs_pkg::ADC_W-1:0]    adc_value;

  modport source (output valid, output kind, output adc_value, input ready);
  modport sink   (input valid, input kind, input adc_value, output ready);
endinterface

interface scvs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic                        channel;
  logic [scvs_pkg::MV_W-1:0]   voltage_mv;
  logic [scvs_pkg::MV_W-1:0]   supply_mv;
  logic                        divide_error;

  modport source (output valid, output result_kind, output channel, output voltage_mv,
                  output supply_mv, output divide_error, input ready);
  modport sink   (input valid, input result_kind, input channel, input voltage_mv,
                  input supply_mv, input divide_error, output ready);
endinterface

interface scvs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [scvs_pkg::CFG_IDX_W-1:0]   index;
  logic [scvs_pkg::WAIT_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/scvs_serial_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on scvs_pkg
`timescale 1ns / 1ps

module scvs_serial_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  scvs_pkg::scvs_div_req_t req_i,
  output scvs_pkg::scvs_div_rsp_t rsp_o
);

  logic [scvs_pkg::DATA_W-1:0] dvd_q, dvd_d;
  logic [scvs_pkg::DEN_W-1:0]  rem_q, rem_d;
  logic [scvs_pkg::DEN_W-1:0]  den_q;
  logic [scvs_pkg::ITER_W-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic [scvs_pkg::DEN_W+1:0]  trial;
  logic                        qbit;

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_comb begin
    trial = {1'b0, rem_q, dvd_q[scvs_pkg::DATA_W-1]} - {2'b00, den_q};
    qbit  = ~trial[scvs_pkg::DEN_W+1];
    rem_d = qbit ? trial[scvs_pkg::DEN_W-1:0]
                 : {rem_q[scvs_pkg::DEN_W-2:0], dvd_q[scvs_pkg::DATA_W-1]};
    dvd_d = {dvd_q[scvs_pkg::DATA_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == scvs_pkg::ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// ===== rtl/core/supply_compensated_voltage_sampler.sv =====
// top level of the supply compensated voltage sampler: tick counter, sequencer,
// shift-add multiplier and output register
// depends on scvs_pkg, scvs_if (interfaces) and scvs_serial_div
`timescale 1ns / 1ps

// usage
//   in_i carries one beat per event: kind 0 is a timer tick, kind 1 a finished
//   conversion with adc_value. out_o carries start-conversion requests
//   (result_kind 0, channel to convert) and corrected voltages (result_kind 1).
//   cfg_i writes short_wait_ticks (index 0) and long_wait_ticks (index 1);
//   other indexes are dropped. cfg_i is always ready; write only while idle.
// sequence
//   a tick is counted while idle; a tick that reaches the wait passes through EMIT
//   to hand a request to the output register. a battery conversion runs the shift-add
//   multiply by 5000, then the 23-bit serial divide by 1023.
//   a reference conversion runs through the one shared divider: two divides of 21
//   quotient bits, a shift-add multiply by the raw value, a divide of 31 quotient
//   bits, then the result is emitted.
//   in_i is ready only while the sequencer is idle.
// reset
//   waits return to 16 and 625, tick count and phase clear, battery phase first.
// back-pressure
//   one output register; a new beat is still taken while a result waits there,
//   and a second result holds the sequencer until out_o drains.

module supply_compensated_voltage_sampler (
  input  logic       clk_i,
  input  logic       rst_ni,
  scvs_in_if.sink    in_i,
  scvs_out_if.source out_o,
  scvs_cfg_if.sink   cfg_i
);

  // configuration and event state
  logic [scvs_pkg::WAIT_W-1:0]   short_wait_q, long_wait_q;
  logic [scvs_pkg::WAIT_W-1:0]   tick_cnt_q, wait_lim_q;
  logic [scvs_pkg::WAIT_W-1:0]   tick_next;
  logic                          ref_phase_q;
  logic [scvs_pkg::RAW_W-1:0]    raw_mv_q;
  scvs_pkg::scvs_state_e         state_q;

  // datapath
  logic [scvs_pkg::ADC_W-1:0]    adc_q;
  logic [scvs_pkg::SUPPLY_W-1:0] supply_q;
  logic [scvs_pkg::DATA_W-1:0]   acc_q, mcand_q;
  logic [scvs_pkg::RAW_W-1:0]    mplier_q;
  logic                          div_start_q;

  // pending result and output register
  logic                          res_kind_q, res_chan_q, res_err_q;
  logic [scvs_pkg::MV_W-1:0]     res_volt_q, res_sup_q;
  logic                          out_valid_q, out_kind_q, out_chan_q, out_err_q;
  logic [scvs_pkg::MV_W-1:0]     out_volt_q, out_sup_q;

  logic                          in_beat, out_load, mul_done;
  logic [scvs_pkg::SUPPLY_W-1:0] quo21;

  scvs_pkg::scvs_div_req_t       div_req;
  scvs_pkg::scvs_div_rsp_t       div_rsp;

  assign in_i.ready  = (state_q == scvs_pkg::ST_IDLE);
  assign in_beat     = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign tick_next   = tick_cnt_q + 1'b1;
  assign mul_done    = (mplier_q == '0);
  assign out_load    = (state_q == scvs_pkg::ST_EMIT) & (~out_valid_q | out_o.ready);
  assign quo21       = div_rsp.quotient[scvs_pkg::SUPPLY_W-1:0];

  // operands for the shared divider, chosen by the step in progress;
  // dividends are left-aligned so the quotient ends in the low bits
  always_comb begin
    div_req.start    = div_start_q;
    div_req.iters    = scvs_pkg::ITERS_RAW;
    div_req.dividend = {acc_q[22:0], 9'd0};
    div_req.divisor  = scvs_pkg::FULL_SCALE;
    unique case (state_q)
      scvs_pkg::ST_DIV_SUP: begin
        div_req.iters    = scvs_pkg::ITERS_SUP;
        div_req.dividend = {scvs_pkg::REF_NUMER, 11'd0};
        div_req.divisor  = adc_q;
      end
      scvs_pkg::ST_DIV_SCL: begin
        div_req.iters    = scvs_pkg::ITERS_SCL;
        div_req.dividend = {supply_q, 11'd0};
        div_req.divisor  = scvs_pkg::SUPPLY_DIV;
      end
      scvs_pkg::ST_DIV_VLT: begin
        div_req.iters    = scvs_pkg::ITERS_VLT;
        div_req.dividend = {acc_q[30:0], 1'b0};
        div_req.divisor  = scvs_pkg::MV_PER_V;
      end
      default: begin
      end
    endcase
  end

  scvs_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_wait_q <= scvs_pkg::SHORT_WAIT_RST;
      long_wait_q  <= scvs_pkg::LONG_WAIT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        scvs_pkg::REG_SHORT_WAIT: short_wait_q <= cfg_i.data;
        scvs_pkg::REG_LONG_WAIT:  long_wait_q  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scvs_pkg::ST_IDLE;
      tick_cnt_q  <= '0;
      wait_lim_q  <= scvs_pkg::SHORT_WAIT_RST;
      ref_phase_q <= 1'b0;
      raw_mv_q    <= '0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      unique case (state_q)
        scvs_pkg::ST_IDLE: begin
          if (in_beat) begin
            if (in_i.kind == scvs_pkg::KIND_TICK) begin
              // count wraps at 16 bits, so a zero wait matches after a full lap
              if (tick_next == wait_lim_q) begin
                tick_cnt_q <= '0;
                state_q    <= scvs_pkg::ST_EMIT;
              end else begin
                tick_cnt_q <= tick_next;
              end
            end else if (!ref_phase_q) begin
              state_q <= scvs_pkg::ST_MUL_RAW;
            end else begin
              // reference reading ends the cycle: back to battery, long wait
              wait_lim_q  <= long_wait_q;
              ref_phase_q <= 1'b0;
              if (in_i.adc_value == '0) begin
                state_q <= scvs_pkg::ST_EMIT;
              end else begin
                state_q     <= scvs_pkg::ST_DIV_SUP;
                div_start_q <= 1'b1;
              end
            end
          end
        end
        scvs_pkg::ST_MUL_RAW: begin
          if (mul_done) begin
            state_q     <= scvs_pkg::ST_DIV_RAW;
            div_start_q <= 1'b1;
          end
        end
        scvs_pkg::ST_DIV_RAW: begin
          if (div_rsp.done) begin
            raw_mv_q    <= div_rsp.quotient[scvs_pkg::RAW_W-1:0];
            wait_lim_q  <= short_wait_q;
            ref_phase_q <= 1'b1;
            state_q     <= scvs_pkg::ST_IDLE;
          end
        end
        scvs_pkg::ST_DIV_SUP: begin
          if (div_rsp.done) begin
            state_q     <= scvs_pkg::ST_DIV_SCL;
            div_start_q <= 1'b1;
          end
        end
        scvs_pkg::ST_DIV_SCL: begin
          if (div_rsp.done) begin
            state_q <= scvs_pkg::ST_MUL_VLT;
          end
        end
        scvs_pkg::ST_MUL_VLT: begin
          if (mul_done) begin
            state_q     <= scvs_pkg::ST_DIV_VLT;
            div_start_q <= 1'b1;
          end
        end
        scvs_pkg::ST_DIV_VLT: begin
          if (div_rsp.done) begin
            state_q <= scvs_pkg::ST_EMIT;
          end
        end
        scvs_pkg::ST_EMIT: begin
          if (out_load) begin
            state_q <= scvs_pkg::ST_IDLE;
          end
        end
        default: state_q <= scvs_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath: shift-add multiplier, one multiplier bit per cycle,
  // and the pending result fields
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      scvs_pkg::ST_IDLE: begin
        if (in_beat) begin
          adc_q    <= in_i.adc_value;
          acc_q    <= '0;
          mcand_q  <= {19'd0, scvs_pkg::NOMINAL_MV};
          mplier_q <= {3'd0, in_i.adc_value};
          // request fields; a zero reference reading overwrites them below
          res_kind_q <= scvs_pkg::RES_REQUEST;
          res_chan_q <= ref_phase_q;
          res_volt_q <= '0;
          res_sup_q  <= '0;
          res_err_q  <= 1'b0;
          if (in_i.kind == scvs_pkg::KIND_CONV && ref_phase_q && in_i.adc_value == '0) begin
            res_kind_q <= scvs_pkg::RES_VOLTAGE;
            res_chan_q <= scvs_pkg::CH_BATTERY;
            res_err_q  <= 1'b1;
          end
        end
      end
      scvs_pkg::ST_MUL_RAW, scvs_pkg::ST_MUL_VLT: begin
        if (!mul_done) begin
          if (mplier_q[0]) begin
            acc_q <= acc_q + mcand_q;
          end
          mcand_q  <= {mcand_q[scvs_pkg::DATA_W-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[scvs_pkg::RAW_W-1:1]};
        end
      end
      scvs_pkg::ST_DIV_SUP: begin
        if (div_rsp.done) begin
          supply_q <= quo21;
        end
      end
      scvs_pkg::ST_DIV_SCL: begin
        if (div_rsp.done) begin
          acc_q    <= '0;
          mcand_q  <= {14'd0, div_rsp.quotient[scvs_pkg::SCALED_W-1:0]};
          mplier_q <= raw_mv_q;
        end
      end
      scvs_pkg::ST_DIV_VLT: begin
        if (div_rsp.done) begin
          res_kind_q <= scvs_pkg::RES_VOLTAGE;
          res_chan_q <= scvs_pkg::CH_BATTERY;
          res_err_q  <= 1'b0;
          // both fields saturate at 16 bits
          res_volt_q <= (|quo21[scvs_pkg::SUPPLY_W-1:scvs_pkg::MV_W])
                        ? '1 : quo21[scvs_pkg::MV_W-1:0];
          res_sup_q  <= (|supply_q[scvs_pkg::SUPPLY_W-1:scvs_pkg::MV_W])
                        ? '1 : supply_q[scvs_pkg::MV_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= res_kind_q;
      out_chan_q <= res_chan_q;
      out_volt_q <= res_volt_q;
      out_sup_q  <= res_sup_q;
      out_err_q  <= res_err_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = out_kind_q;
  assign out_o.channel      = out_chan_q;
  assign out_o.voltage_mv   = out_volt_q;
  assign out_o.supply_mv    = out_sup_q;
  assign out_o.divide_error = out_err_q;

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for supply_compensated_voltage_sampler: event driver, config writer,
// result monitor and a scoreboard class that recomputes every reading from the accepted beats
// depends on scvs_pkg, the scvs_if interfaces and the sampler rtl
`timescale 1ns / 1ps

module tb_top;
  import scvs_pkg::*;

  // the package only names the battery channel, the reference is the other one
  localparam logic CH_REFERENCE = ~CH_BATTERY;

  // longer than a reference conversion, so this covers any work still in flight
  localparam int unsigned SETTLE_CYCLES = 200;
  // well-formed sequences only tick up to a request when it is this close
  localparam int unsigned NEAR_TICKS    = 48;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_EVENTS  = 78;
  // slowest legal run is about 1 ms, even with ready low in all but one pattern slot
  localparam longint unsigned RUN_LIMIT_NS = 64'd10_000_000;

  // one beat on the result channel
  typedef struct packed {
    logic            result_kind;
    logic            channel;
    logic [MV_W-1:0] voltage_mv;
    logic [MV_W-1:0] supply_mv;
    logic            divide_error;
  } reading_t;

  // tracks the sampler state from accepted beats and keeps the readings it owes
  class voltage_tracker;
    logic [WAIT_W-1:0] short_wait;
    logic [WAIT_W-1:0] long_wait;
    logic [WAIT_W-1:0] tick_count;
    logic [WAIT_W-1:0] wait_limit;
    logic              on_reference;
    logic [RAW_W-1:0]  raw_mv;
    reading_t          due_readings[$];
    int unsigned       failures;

    function new();
      short_wait   = SHORT_WAIT_RST;
      long_wait    = LONG_WAIT_RST;
      tick_count   = '0;
      wait_limit   = SHORT_WAIT_RST;
      on_reference = 1'b0;
      raw_mv       = '0;
      failures     = 0;
    endfunction

    // new waits only land in wait_limit at the next phase change
    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [WAIT_W-1:0] value);
      if (idx == REG_SHORT_WAIT) begin
        short_wait = value;
      end else if (idx == REG_LONG_WAIT) begin
        long_wait = value;
      end
    endfunction

    function logic [MV_W-1:0] clip_mv(longint unsigned v);
      return ((v >> MV_W) != 0) ? '1 : v[MV_W-1:0];
    endfunction

    function void apply_event(logic kind, logic [ADC_W-1:0] adc);
      reading_t          want;
      longint unsigned   acc;
      longint unsigned   supply;
      longint unsigned   scaled;
      want = '0;
      if (kind == KIND_TICK) begin
        // counter is 16 bits and wraps
        tick_count = tick_count + 1'b1;
        if (tick_count == wait_limit) begin
          tick_count        = '0;
          want.result_kind  = RES_REQUEST;
          want.channel      = on_reference ? CH_REFERENCE : CH_BATTERY;
          due_readings.push_back(want);
        end
      end else if (!on_reference) begin
        // battery reading against a nominal 5 V supply, no reading out
        acc          = adc;
        raw_mv       = RAW_W'((acc * NOMINAL_MV) / FULL_SCALE);
        wait_limit   = short_wait;
        on_reference = 1'b1;
      end else begin
        wait_limit        = long_wait;
        on_reference      = 1'b0;
        want.result_kind  = RES_VOLTAGE;
        want.channel      = CH_BATTERY;
        if (adc == '0) begin
          // zero bandgap reading: flag it, both values stay zero
          want.divide_error = 1'b1;
        end else begin
          // supply kept at full width through the correction, clipped only at the port
          supply          = REF_NUMER / adc;
          scaled          = (supply * MV_PER_V) / NOMINAL_MV;
          acc             = (scaled * raw_mv) / MV_PER_V;
          want.voltage_mv = clip_mv(acc);
          want.supply_mv  = clip_mv(supply);
        end
        due_readings.push_back(want);
      end
    endfunction

    function int ticks_to_request();
      logic [WAIT_W-1:0] left;
      left = wait_limit - tick_count;
      return (left == '0) ? (1 << WAIT_W) : int'(left);
    endfunction

    // wait that the next conversion will load
    function int next_wait();
      return on_reference ? int'(long_wait) : int'(short_wait);
    endfunction

    task report(string what);
      failures++;
      if (failures <= 40) begin
        $display("%0t mismatch: %s", $time, what);
      end
    endtask

    task compare_field(string name, logic [MV_W-1:0] got, logic [MV_W-1:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0d expected %0d", name, got, want));
      end
    endtask

    task check_reading(logic rk, logic ch, logic [MV_W-1:0] volt, logic [MV_W-1:0] supply,
                       logic err);
      reading_t want;
      if (due_readings.size() == 0) begin
        report($sformatf("reading with none pending: kind %0d channel %0d", rk, ch));
        return;
      end
      want = due_readings.pop_front();
      compare_field("result_kind", MV_W'(rk), MV_W'(want.result_kind));
      compare_field("channel", MV_W'(ch), MV_W'(want.channel));
      compare_field("voltage_mv", volt, want.voltage_mv);
      compare_field("supply_mv", supply, want.supply_mv);
      compare_field("divide_error", MV_W'(err), MV_W'(want.divide_error));
    endtask

    task close_out();
      if (due_readings.size() != 0) begin
        report($sformatf("%0d readings never arrived", due_readings.size()));
      end
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  scvs_in_if  in_bus ();
  scvs_out_if out_bus ();
  scvs_cfg_if cfg_bus ();

  supply_compensated_voltage_sampler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  voltage_tracker sb;

  // sender burst shaping, set per phase
  int burst_left;
  int burst_max;
  int gap_max;

  // receiver stall pattern, one bit per cycle, rotated forever
  logic [15:0] ready_pattern;
  logic [3:0]  stall_pos = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      stall_pos     <= stall_pos + 1'b1;
      out_bus.ready <= ready_pattern[stall_pos];
    end
  end

  // every accepted result beat is checked against the oldest owed reading
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      sb.check_reading(out_bus.result_kind, out_bus.channel, out_bus.voltage_mv,
                       out_bus.supply_mv, out_bus.divide_error);
    end
  end

  // mostly random values, with the edges and single-bit values mixed in
  function automatic logic [ADC_W-1:0] pick_adc();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ADC_W'(1);
      2:       return '1;
      3:       return ADC_W'(1) << $urandom_range(0, ADC_W - 1);
      default: return ADC_W'($urandom);
    endcase
  endfunction

  // one event beat; the tracker is updated here at the accepting edge so the
  // stimulus generator always sees the state after its own last beat
  task automatic send_event(input logic kind, input logic [ADC_W-1:0] adc);
    int gap;
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= kind;
    in_bus.adc_value <= adc;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.apply_event(kind, adc);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // end of burst: maybe drop valid for a while, gap 0 keeps streaming
      burst_left = $urandom_range(1, burst_max);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // hold keeps valid up so back-to-back writes never drop it in between
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [WAIT_W-1:0] value, input bit hold);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    sb.apply_write(idx, value);
    if (!hold) cfg_bus.valid <= 1'b0;
  endtask

  // both waits plus one write to an index past the register list, which must be dropped
  task automatic configure(input logic [WAIT_W-1:0] short_v, input logic [WAIT_W-1:0] long_v,
                           input logic [CFG_IDX_W-1:0] stray_idx,
                           input logic [WAIT_W-1:0] stray_data);
    write_register(REG_SHORT_WAIT, short_v, 1'b1);
    write_register(stray_idx, stray_data, 1'b1);
    write_register(REG_LONG_WAIT, long_v, 1'b0);
  endtask

  // let every owed reading drain, then give a battery conversion time to finish
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.due_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  // mostly tick-to-request-then-convert sequences, with stray ticks and unrequested
  // conversions; ticks and conversions are held back where they would push the count
  // past the wait that comes next, which would otherwise cost a full 16-bit wrap
  task automatic run_random_phase(input int count_items);
    int left;
    int gap;
    int cnt;
    int next_lim;
    int n;
    int pick;
    left = count_items;
    while (left > 0) begin
      gap      = sb.ticks_to_request();
      cnt      = int'(sb.tick_count);
      next_lim = sb.next_wait();
      pick     = $urandom_range(0, 99);
      if (pick < 10 && cnt < next_lim) begin
        // conversion nobody asked for
        send_event(KIND_CONV, pick_adc());
        left--;
      end else if (pick < 20) begin
        // a few stray ticks
        n = $urandom_range(1, 4);
        if (n > gap) n = gap;
        if (n < gap && cnt + n >= next_lim) n = 0;
        repeat (n) send_event(KIND_TICK, pick_adc());
        left -= n;
      end else if (gap <= NEAR_TICKS || cnt >= next_lim) begin
        // full round: count up to the request, then deliver the conversion
        repeat (gap) send_event(KIND_TICK, pick_adc());
        send_event(KIND_CONV, pick_adc());
        left -= gap + 1;
      end else begin
        // request too far off, move the phase along instead
        send_event(KIND_CONV, pick_adc());
        left--;
      end
    end
  endtask

  // hard stop in case a handshake never completes
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [WAIT_W-1:0] short_v;
    logic [WAIT_W-1:0] long_v;

    sb = new();
    in_bus.valid     <= 1'b0;
    in_bus.kind      <= KIND_TICK;
    in_bus.adc_value <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= REG_SHORT_WAIT;
    cfg_bus.data     <= '0;
    ready_pattern    <= '1;
    burst_left = 0;
    burst_max  = 4;
    gap_max    = 2;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset waits: first request after the default short wait, on the battery
    ready_pattern <= 16'($urandom) | 16'h1;
    repeat (SHORT_WAIT_RST) send_event(KIND_TICK, pick_adc());
    send_event(KIND_CONV, '1);

    // shortest waits, all-ones stray write, then the corner readings
    settle();
    configure(WAIT_W'(1), WAIT_W'(1), '1, '1);
    send_event(KIND_CONV, ADC_W'(1));   // unrequested reference read, both values clip
    send_event(KIND_TICK, '0);
    send_event(KIND_CONV, '0);          // battery at zero
    send_event(KIND_TICK, '1);
    send_event(KIND_CONV, '0);          // zero bandgap, divide error
    send_event(KIND_TICK, '0);
    send_event(KIND_CONV, '1);          // full-scale battery
    send_event(KIND_TICK, '1);
    send_event(KIND_CONV, '1);          // full-scale bandgap, nothing clips
    send_event(KIND_CONV, 10'd512);     // unrequested battery read
    send_event(KIND_CONV, ADC_W'(1));   // smallest bandgap read, mid raw

    // random phases over a spread of waits and idling shapes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          short_v = WAIT_W'($urandom_range(1, 8));
          long_v  = WAIT_W'($urandom_range(1, 8));
        end
        1: begin
          // reference request is mostly out of reach, unrequested reads move the phase
          short_v = WAIT_W'($urandom_range(NEAR_TICKS + 1, 2 * NEAR_TICKS));
          long_v  = WAIT_W'($urandom_range(2, 8));
        end
        2: begin
          short_v = WAIT_W'($urandom_range(1, 40));
          long_v  = WAIT_W'($urandom_range(1, 40));
        end
        3: begin
          short_v = WAIT_W'($urandom_range(1, 4));
          long_v  = WAIT_W'($urandom_range(NEAR_TICKS + 1, 2 * NEAR_TICKS));
        end
        default: begin
          short_v = WAIT_W'($urandom_range(1, 16));
          long_v  = WAIT_W'($urandom_range(1, 24));
        end
      endcase
      configure(short_v, long_v,
                CFG_IDX_W'($urandom_range(REG_LONG_WAIT + 1, (1 << CFG_IDX_W) - 1)),
                WAIT_W'($urandom));
      // phase 2 runs with no idling on either side
      gap_max       = (p == 2) ? 0 : $urandom_range(1, 4);
      burst_max     = $urandom_range(1, 12);
      ready_pattern <= (p == 2) ? '1 : (16'($urandom) | 16'h1);
      run_random_phase(PHASE_EVENTS);
    end

    settle();
    sb.close_out();
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
